// ----- rtl/core/gbcr_pkg.sv -----
`default_nettype none

package gbcr_pkg;

  // fixed field widths
  localparam int unsigned CP_W        = 21;
  localparam int unsigned BLK_W       = 8;
  localparam int unsigned CHR_W       = 8;
  localparam int unsigned SLOT_OUT_W  = 4;
  localparam int unsigned BLOCK_COUNT = 256;

  // code point handling
  localparam logic [15:0] REPLACE_CP = 16'hFFFD;

  // default sizing
  localparam int unsigned DEF_STATIC_SLOTS = 8;
  localparam int unsigned DEF_TEMP_SLOTS   = 8;
  localparam int unsigned DEF_COUNT_WIDTH  = 16;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_SCAN,
    ST_EVICT
  } gbcr_state_e;

  // commands from controller to datapath
  typedef struct packed {
    logic load;
    logic lookup;
    logic hit_done;
    logic fill;
    logic scan_start;
    logic scan_run;
    logic pick;
    logic evict;
  } gbcr_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic cached;
    logic full;
    logic scan_done;
  } gbcr_status_t;

endpackage

`default_nettype wire

// ----- rtl/core/gbcr_ctrl.sv -----
`default_nettype none

module gbcr_ctrl (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire gbcr_pkg::gbcr_status_t status_i,
  output gbcr_pkg::gbcr_cmd_t        cmd_o,
  output logic                       busy_o
);
  import gbcr_pkg::*;

  gbcr_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = (state_q != ST_IDLE);
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        cmd_o.lookup = 1'b1;
        priority if (status_i.cached) begin
          cmd_o.hit_done = 1'b1;
          state_d        = ST_IDLE;
        end else if (!status_i.full) begin
          cmd_o.fill = 1'b1;
          state_d    = ST_IDLE;
        end else begin
          cmd_o.scan_start = 1'b1;
          state_d          = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status_i.scan_done) begin
          cmd_o.pick = 1'b1;
          state_d    = ST_EVICT;
        end else begin
          cmd_o.scan_run = 1'b1;
        end
      end
      ST_EVICT: begin
        cmd_o.evict = 1'b1;
        state_d     = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/core/gbcr_datapath.sv -----
`default_nettype none

module gbcr_datapath #(
  parameter int unsigned STATIC_SLOTS = gbcr_pkg::DEF_STATIC_SLOTS,
  parameter int unsigned TEMP_SLOTS   = gbcr_pkg::DEF_TEMP_SLOTS,
  parameter int unsigned COUNT_WIDTH  = gbcr_pkg::DEF_COUNT_WIDTH
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire gbcr_pkg::gbcr_cmd_t               cmd_i,
  output gbcr_pkg::gbcr_status_t                 status_o,
  input  wire logic [gbcr_pkg::CP_W-1:0]         code_point_i,
  output logic                                   result_valid_o,
  output logic [gbcr_pkg::SLOT_OUT_W-1:0]        slot_o,
  output logic [gbcr_pkg::BLK_W-1:0]             block_number_o,
  output logic [gbcr_pkg::CHR_W-1:0]             char_index_o,
  output logic                                   hit_o,
  output logic                                   evict_valid_o,
  output logic [gbcr_pkg::BLK_W-1:0]             evicted_block_o
);
  import gbcr_pkg::*;

  localparam int unsigned ALL_SLOTS = STATIC_SLOTS + TEMP_SLOTS;
  localparam int unsigned SLOT_W    = $clog2(ALL_SLOTS);
  localparam int unsigned FILL_W    = $clog2(ALL_SLOTS + 1);
  localparam int unsigned SCAN_W    = $clog2(STATIC_SLOTS + 1);

  // memories
  logic [COUNT_WIDTH-1:0] cnt_mem   [BLOCK_COUNT];
  logic [SLOT_W-1:0]      b2s_mem   [BLOCK_COUNT];
  logic [BLK_W-1:0]       owner_mem [ALL_SLOTS];

  // per-block flags
  logic [BLOCK_COUNT-1:0] cvld_q;
  logic [BLOCK_COUNT-1:0] cached_q;

  logic [FILL_W-1:0]      filled_q;
  logic [SLOT_W-1:0]      rr_q;

  // item registers
  logic [BLK_W-1:0]       blk_q;
  logic [CHR_W-1:0]       chr_q;
  logic [COUNT_WIDTH-1:0] cnt_rd_q;
  logic [COUNT_WIDTH-1:0] cnt_new_q;
  logic [SLOT_W-1:0]      b2s_rd_q;
  logic [BLK_W-1:0]       owner_rd_q;
  logic [SLOT_W-1:0]      pos_q;

  // scan pipeline
  logic [SCAN_W-1:0]      scan_idx_q;
  logic                   s1_vld_q, s2_vld_q;
  logic [SLOT_W-1:0]      s1_idx_q, s2_idx_q;
  logic [COUNT_WIDTH-1:0] min_q;
  logic [SLOT_W-1:0]      minpos_q;
  logic                   scan_done_q;

  // result registers
  logic                   res_vld_q;
  logic [SLOT_OUT_W-1:0]  res_slot_q;
  logic [BLK_W-1:0]       res_blk_q;
  logic [CHR_W-1:0]       res_chr_q;
  logic                   res_hit_q;
  logic                   res_ev_q;
  logic [BLK_W-1:0]       res_evb_q;

  logic [15:0]            cp_eff;
  logic [BLK_W-1:0]       blk_in;
  logic [CHR_W-1:0]       chr_in;
  logic [COUNT_WIDTH-1:0] cnt_inc;
  logic                   scan_issue;
  logic                   to_temp;
  logic [SLOT_W-1:0]      rr_nxt;
  logic [SLOT_W-1:0]      pos_d;
  logic [SLOT_W-1:0]      fill_pos;
  logic [BLK_W-1:0]       cnt_raddr;
  logic [SLOT_W-1:0]      owner_raddr;
  logic                   owner_we;
  logic [SLOT_W-1:0]      owner_waddr;

  // out-of-plane code points map to the replacement character
  assign cp_eff = (|code_point_i[CP_W-1:16]) ? REPLACE_CP : code_point_i[15:0];
  assign blk_in = cp_eff[15:8];
  assign chr_in = cp_eff[7:0];

  // saturating use count
  assign cnt_inc = (cnt_rd_q == '1) ? cnt_rd_q : cnt_rd_q + COUNT_WIDTH'(1);

  assign scan_issue = cmd_i.scan_run && (scan_idx_q < SCAN_W'(STATIC_SLOTS));
  assign fill_pos   = SLOT_W'(filled_q);

  // victim choice: temporary round robin or least-used static slot
  assign to_temp = (cnt_new_q <= min_q);
  assign rr_nxt  = (rr_q == SLOT_W'(ALL_SLOTS - 1)) ? SLOT_W'(STATIC_SLOTS)
                                                    : rr_q + SLOT_W'(1);
  assign pos_d   = to_temp ? rr_nxt : minpos_q;

  // read and write address selection
  assign cnt_raddr   = cmd_i.load ? blk_in : owner_rd_q;
  assign owner_raddr = cmd_i.pick ? pos_d : SLOT_W'(scan_idx_q);
  assign owner_we    = cmd_i.fill || cmd_i.evict;
  assign owner_waddr = cmd_i.fill ? fill_pos : pos_q;

  // use count memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.lookup) begin
      cnt_mem[blk_q] <= cnt_inc;
    end
    cnt_rd_q <= cvld_q[cnt_raddr] ? cnt_mem[cnt_raddr] : '0;
  end

  // block to slot memory
  always_ff @(posedge clk_i) begin
    if (owner_we) begin
      b2s_mem[blk_q] <= owner_waddr;
    end
    b2s_rd_q <= b2s_mem[blk_in];
  end

  // slot owner memory
  always_ff @(posedge clk_i) begin
    if (owner_we) begin
      owner_mem[owner_waddr] <= blk_q;
    end
    owner_rd_q <= owner_mem[owner_raddr];
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cvld_q      <= '0;
      cached_q    <= '0;
      filled_q    <= '0;
      rr_q        <= SLOT_W'(STATIC_SLOTS);
      scan_idx_q  <= '0;
      s1_vld_q    <= 1'b0;
      s2_vld_q    <= 1'b0;
      scan_done_q <= 1'b0;
      res_vld_q   <= 1'b0;
    end else begin
      res_vld_q <= cmd_i.hit_done || cmd_i.fill || cmd_i.evict;
      if (cmd_i.lookup) begin
        cvld_q[blk_q] <= 1'b1;
      end
      if (cmd_i.fill) begin
        cached_q[blk_q] <= 1'b1;
        filled_q        <= filled_q + FILL_W'(1);
      end
      if (cmd_i.evict) begin
        cached_q[owner_rd_q] <= 1'b0;
        cached_q[blk_q]      <= 1'b1;
      end
      if (cmd_i.pick && to_temp) begin
        rr_q <= rr_nxt;
      end
      // scan sequencing
      if (cmd_i.scan_start) begin
        scan_idx_q <= '0;
      end else if (scan_issue) begin
        scan_idx_q <= scan_idx_q + SCAN_W'(1);
      end
      s1_vld_q <= scan_issue;
      s2_vld_q <= s1_vld_q;
      if (cmd_i.scan_start) begin
        scan_done_q <= 1'b0;
      end else if (s2_vld_q && (s2_idx_q == SLOT_W'(STATIC_SLOTS - 1))) begin
        scan_done_q <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      blk_q <= blk_in;
      chr_q <= chr_in;
    end
    if (cmd_i.lookup) begin
      cnt_new_q <= cnt_inc;
    end
    s1_idx_q <= SLOT_W'(scan_idx_q);
    s2_idx_q <= s1_idx_q;
    // running minimum, earliest slot wins ties
    if (s2_vld_q && ((s2_idx_q == '0) || (cnt_rd_q < min_q))) begin
      min_q    <= cnt_rd_q;
      minpos_q <= s2_idx_q;
    end
    if (cmd_i.pick) begin
      pos_q <= pos_d;
    end
    if (cmd_i.hit_done) begin
      res_slot_q <= SLOT_OUT_W'(b2s_rd_q);
      res_hit_q  <= 1'b1;
      res_ev_q   <= 1'b0;
      res_evb_q  <= '0;
    end else if (cmd_i.fill) begin
      res_slot_q <= SLOT_OUT_W'(fill_pos);
      res_hit_q  <= 1'b0;
      res_ev_q   <= 1'b0;
      res_evb_q  <= '0;
    end else if (cmd_i.evict) begin
      res_slot_q <= SLOT_OUT_W'(pos_q);
      res_hit_q  <= 1'b0;
      res_ev_q   <= 1'b1;
      res_evb_q  <= owner_rd_q;
    end
    if (cmd_i.hit_done || cmd_i.fill || cmd_i.evict) begin
      res_blk_q <= blk_q;
      res_chr_q <= chr_q;
    end
  end

  // status and outputs
  assign status_o.cached    = cached_q[blk_q];
  assign status_o.full      = (filled_q == FILL_W'(ALL_SLOTS));
  assign status_o.scan_done = scan_done_q;

  assign result_valid_o  = res_vld_q;
  assign slot_o          = res_slot_q;
  assign block_number_o  = res_blk_q;
  assign char_index_o    = res_chr_q;
  assign hit_o           = res_hit_q;
  assign evict_valid_o   = res_ev_q;
  assign evicted_block_o = res_evb_q;

  // checks
  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld_q |=> !res_vld_q)
    else $error("result strobe held for more than one cycle");

  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    filled_q <= FILL_W'(ALL_SLOTS))
    else $error("fill count beyond slot count");

  a_rr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rr_q >= SLOT_W'(STATIC_SLOTS)) && (rr_q <= SLOT_W'(ALL_SLOTS - 1)))
    else $error("round robin pointer outside temporary slots");

  a_evict_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.pick || cmd_i.evict) |-> status_o.full)
    else $error("replacement while free slots remain");

  a_evict_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_vld_q && res_ev_q) |-> !res_hit_q)
    else $error("eviction reported on a hit");

endmodule

`default_nettype wire

// ----- rtl/core/glyph_block_cache_replacement_top.sv -----
`default_nettype none

// Glyph block cache slot allocator with least-frequently-used replacement.
// Command channel: drive code_point_i and raise start_i; the item is taken
// at a rising edge where start_i is high and busy_o is low. busy_o stays
// high while the item is being worked on.
// Result channel: result_valid_o strobes for exactly one cycle with slot_o,
// block_number_o, char_index_o, hit_o, evict_valid_o and evicted_block_o.
// The receiver cannot stall; results must be captured in the strobe cycle.
// Path from the accept edge to the strobe: a hit or the fill of a free slot
// passes the lookup state and then the result register; a replacement when
// all slots are full passes the lookup, scan and evict states and then the
// result register. The scan reads each static slot owner and its use count
// through the single read ports of the owner and count memories, one slot
// per cycle, two stages deep.
// A new item may be started in the strobe cycle itself.
// Reset clears all use counts and cached flags (flag registers, no
// clearing pass), empties the slots and sets the round robin pointer to
// the first temporary slot; the block is ready straight after reset.
module glyph_block_cache_replacement_top #(
  parameter int unsigned STATIC_SLOTS = gbcr_pkg::DEF_STATIC_SLOTS,
  parameter int unsigned TEMP_SLOTS   = gbcr_pkg::DEF_TEMP_SLOTS,
  parameter int unsigned COUNT_WIDTH  = gbcr_pkg::DEF_COUNT_WIDTH
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  output logic                               busy_o,
  input  wire logic [gbcr_pkg::CP_W-1:0]     code_point_i,
  output logic                               result_valid_o,
  output logic [gbcr_pkg::SLOT_OUT_W-1:0]    slot_o,
  output logic [gbcr_pkg::BLK_W-1:0]         block_number_o,
  output logic [gbcr_pkg::CHR_W-1:0]         char_index_o,
  output logic                               hit_o,
  output logic                               evict_valid_o,
  output logic [gbcr_pkg::BLK_W-1:0]         evicted_block_o
);
  import gbcr_pkg::*;

  gbcr_cmd_t    cmd;
  gbcr_status_t status;

  // sequencing
  gbcr_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o)
  );

  // tables, scan and result registers
  gbcr_datapath #(
    .STATIC_SLOTS (STATIC_SLOTS),
    .TEMP_SLOTS   (TEMP_SLOTS),
    .COUNT_WIDTH  (COUNT_WIDTH)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .code_point_i    (code_point_i),
    .result_valid_o  (result_valid_o),
    .slot_o          (slot_o),
    .block_number_o  (block_number_o),
    .char_index_o    (char_index_o),
    .hit_o           (hit_o),
    .evict_valid_o   (evict_valid_o),
    .evicted_block_o (evicted_block_o)
  );

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
  import gbcr_pkg::*;

  localparam int unsigned STATIC_N = DEF_STATIC_SLOTS;
  localparam int unsigned ALL_N    = DEF_STATIC_SLOTS + DEF_TEMP_SLOTS;
  localparam int unsigned COUNT_W  = DEF_COUNT_WIDTH;
  localparam int          GAP_MAX  = 18;
  localparam int          RAND_ITEMS = 1525;
  localparam int          WORKSET_N = 24;
  localparam int          DRAIN_CYCLES = 40;

  // one result item as the block reports it
  typedef struct packed {
    logic [SLOT_OUT_W-1:0] slot;
    logic [BLK_W-1:0]      blk;
    logic [CHR_W-1:0]      chr;
    logic                  hit;
    logic                  ev;
    logic [BLK_W-1:0]      victim;
  } glyph_res_t;

  // directed stimulus row, with a fixed answer where it is obvious
  typedef struct packed {
    logic [CP_W-1:0] cp;
    logic            fixed;
    glyph_res_t      res;
  } glyph_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  start_i = 1'b0;
  logic [CP_W-1:0]       code_point_i = '0;
  logic                  busy_o;
  logic                  result_valid_o;
  logic [SLOT_OUT_W-1:0] slot_o;
  logic [BLK_W-1:0]      block_number_o;
  logic [CHR_W-1:0]      char_index_o;
  logic                  hit_o;
  logic                  evict_valid_o;
  logic [BLK_W-1:0]      evicted_block_o;

  glyph_block_cache_replacement_top i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .code_point_i    (code_point_i),
    .result_valid_o  (result_valid_o),
    .slot_o          (slot_o),
    .block_number_o  (block_number_o),
    .char_index_o    (char_index_o),
    .hit_o           (hit_o),
    .evict_valid_o   (evict_valid_o),
    .evicted_block_o (evicted_block_o)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow of the cache state
  logic [COUNT_W-1:0] blk_uses [BLOCK_COUNT];
  logic               blk_held [BLOCK_COUNT];
  int unsigned        blk_home [BLOCK_COUNT];
  logic [BLK_W-1:0]   slot_blk [ALL_N];
  int unsigned        slots_used;
  int unsigned        temp_ptr;

  glyph_res_t lookup_q [$];
  int         errors;
  int         n_items, n_hits, n_fills, n_static_repl, n_temp_repl;

  glyph_row_t dir_rows [25];
  logic [BLK_W-1:0] workset [WORKSET_N];
  bit no_gaps;

  // work out slot, hit and victim for one code point, updating the shadow
  function automatic glyph_res_t predict_glyph_lookup(input logic [CP_W-1:0] cp);
    logic [15:0]        eff;
    logic [BLK_W-1:0]   blk;
    int unsigned        pos;
    logic [COUNT_W-1:0] floor_uses;
    glyph_res_t         r;
    eff = (cp > 21'h00FFFF) ? REPLACE_CP : cp[15:0];
    blk = eff[15:8];
    if (blk_uses[blk] != '1) begin
      blk_uses[blk] = blk_uses[blk] + 1'b1;
    end
    r = '0;
    r.blk = blk;
    r.chr = eff[7:0];
    if (blk_held[blk]) begin
      r.hit = 1'b1;
      pos = blk_home[blk];
      n_hits++;
    end else if (slots_used < ALL_N) begin
      pos = slots_used;
      slots_used++;
      n_fills++;
    end else begin
      // least-used static slot, earliest on ties
      pos = 0;
      floor_uses = blk_uses[slot_blk[0]];
      for (int i = 1; i < STATIC_N; i++) begin
        if (blk_uses[slot_blk[i]] < floor_uses) begin
          floor_uses = blk_uses[slot_blk[i]];
          pos = i;
        end
      end
      // not used more often than that: next temporary slot instead
      if (blk_uses[blk] <= floor_uses) begin
        temp_ptr = (temp_ptr + 1 >= ALL_N) ? STATIC_N : temp_ptr + 1;
        pos = temp_ptr;
        n_temp_repl++;
      end else begin
        n_static_repl++;
      end
      r.ev = 1'b1;
      r.victim = slot_blk[pos];
      blk_held[slot_blk[pos]] = 1'b0;
    end
    if (!r.hit) begin
      slot_blk[pos] = blk;
      blk_held[blk] = 1'b1;
      blk_home[blk] = pos;
    end
    r.slot = pos[SLOT_OUT_W-1:0];
    return r;
  endfunction

  // issue one item after a gap and wait for it to be taken
  task automatic send_code(input logic [CP_W-1:0] cp, input int gap, input logic fixed,
                           input glyph_res_t fixed_res);
    glyph_res_t r;
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i      <= 1'b1;
    code_point_i <= cp;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    r = predict_glyph_lookup(cp);
    lookup_q.insert(lookup_q.size(), fixed ? fixed_res : r);
    n_items++;
  endtask

  function automatic int draw_gap();
    if ($urandom_range(0, 39) == 0) begin
      no_gaps = !no_gaps;
    end
    return no_gaps ? 0 : $urandom_range(0, GAP_MAX);
  endfunction

  // mostly a skewed working set a little larger than the cache, plus noise
  function automatic logic [CP_W-1:0] draw_code();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if ($urandom_range(0, 49) == 0) begin
      workset[$urandom_range(0, WORKSET_N - 1)] = 8'($urandom_range(0, 255));
    end
    if (sel < 70) begin
      return {5'b0, workset[$urandom_range(0, $urandom_range(0, WORKSET_N - 1))],
              8'($urandom)};
    end else if (sel < 85) begin
      return CP_W'($urandom);
    end
    return {5'b0, 16'($urandom)};
  endfunction

  task automatic report_field(input string name, input logic [31:0] exp_v,
                              input logic [31:0] act_v);
    $display("%0t: mismatch on %s, expected %0h, actual %0h", $time, name, exp_v, act_v);
    errors++;
  endtask

  // check every result strobe against the oldest expectation
  always @(posedge clk_i) begin
    glyph_res_t exp_r;
    if (rst_ni && result_valid_o === 1'b1) begin
      if (lookup_q.size() == 0) begin
        $display("%0t: result with nothing expected, block %0h", $time, block_number_o);
        errors++;
      end else begin
        exp_r = lookup_q.pop_front();
        if (slot_o !== exp_r.slot) report_field("slot", 32'(exp_r.slot), 32'(slot_o));
        if (block_number_o !== exp_r.blk) report_field("block_number", 32'(exp_r.blk),
                                                       32'(block_number_o));
        if (char_index_o !== exp_r.chr) report_field("char_index", 32'(exp_r.chr),
                                                     32'(char_index_o));
        if (hit_o !== exp_r.hit) report_field("hit", 32'(exp_r.hit), 32'(hit_o));
        if (evict_valid_o !== exp_r.ev) report_field("evict_valid", 32'(exp_r.ev),
                                                     32'(evict_valid_o));
        if (evicted_block_o !== exp_r.victim) report_field("evicted_block",
                                                           32'(exp_r.victim),
                                                           32'(evicted_block_o));
      end
    end
  end

  // stimulus
  initial begin
    glyph_row_t row;
    errors = 0;
    n_items = 0; n_hits = 0; n_fills = 0; n_static_repl = 0; n_temp_repl = 0;
    no_gaps = 1'b0;
    for (int b = 0; b < BLOCK_COUNT; b++) begin
      blk_uses[b] = '0;
      blk_held[b] = 1'b0;
      blk_home[b] = 0;
    end
    slots_used = 0;
    temp_ptr = STATIC_N;

    // empty cache, out-of-plane code points, fill of every slot, then both replacements
    dir_rows[0]  = '{21'h000000, 1'b1, '{4'd0,  8'h00, 8'h00, 1'b0, 1'b0, 8'h00}};
    dir_rows[1]  = '{21'h00FFFF, 1'b1, '{4'd1,  8'hFF, 8'hFF, 1'b0, 1'b0, 8'h00}};
    dir_rows[2]  = '{21'h010000, 1'b1, '{4'd1,  8'hFF, 8'hFD, 1'b1, 1'b0, 8'h00}};
    dir_rows[3]  = '{21'h1FFFFF, 1'b1, '{4'd1,  8'hFF, 8'hFD, 1'b1, 1'b0, 8'h00}};
    dir_rows[4]  = '{21'h10FFFF, 1'b1, '{4'd1,  8'hFF, 8'hFD, 1'b1, 1'b0, 8'h00}};
    dir_rows[5]  = '{21'h110000, 1'b1, '{4'd1,  8'hFF, 8'hFD, 1'b1, 1'b0, 8'h00}};
    dir_rows[6]  = '{21'h000041, 1'b1, '{4'd0,  8'h00, 8'h41, 1'b1, 1'b0, 8'h00}};
    dir_rows[7]  = '{21'h000111, 1'b1, '{4'd2,  8'h01, 8'h11, 1'b0, 1'b0, 8'h00}};
    dir_rows[8]  = '{21'h000222, 1'b1, '{4'd3,  8'h02, 8'h22, 1'b0, 1'b0, 8'h00}};
    dir_rows[9]  = '{21'h000333, 1'b1, '{4'd4,  8'h03, 8'h33, 1'b0, 1'b0, 8'h00}};
    dir_rows[10] = '{21'h000444, 1'b1, '{4'd5,  8'h04, 8'h44, 1'b0, 1'b0, 8'h00}};
    dir_rows[11] = '{21'h000555, 1'b1, '{4'd6,  8'h05, 8'h55, 1'b0, 1'b0, 8'h00}};
    dir_rows[12] = '{21'h000666, 1'b1, '{4'd7,  8'h06, 8'h66, 1'b0, 1'b0, 8'h00}};
    dir_rows[13] = '{21'h000777, 1'b1, '{4'd8,  8'h07, 8'h77, 1'b0, 1'b0, 8'h00}};
    dir_rows[14] = '{21'h000888, 1'b1, '{4'd9,  8'h08, 8'h88, 1'b0, 1'b0, 8'h00}};
    dir_rows[15] = '{21'h000999, 1'b1, '{4'd10, 8'h09, 8'h99, 1'b0, 1'b0, 8'h00}};
    dir_rows[16] = '{21'h000AAA, 1'b1, '{4'd11, 8'h0A, 8'hAA, 1'b0, 1'b0, 8'h00}};
    dir_rows[17] = '{21'h000BBB, 1'b1, '{4'd12, 8'h0B, 8'hBB, 1'b0, 1'b0, 8'h00}};
    dir_rows[18] = '{21'h000CCC, 1'b1, '{4'd13, 8'h0C, 8'hCC, 1'b0, 1'b0, 8'h00}};
    dir_rows[19] = '{21'h000DDD, 1'b1, '{4'd14, 8'h0D, 8'hDD, 1'b0, 1'b0, 8'h00}};
    dir_rows[20] = '{21'h000EEE, 1'b1, '{4'd15, 8'h0E, 8'hEE, 1'b0, 1'b0, 8'h00}};
    dir_rows[21] = '{21'h002000, 1'b1, '{4'd9,  8'h20, 8'h00, 1'b0, 1'b1, 8'h08}};
    dir_rows[22] = '{21'h000810, 1'b0, '0};
    dir_rows[23] = '{21'h0020FF, 1'b0, '0};
    dir_rows[24] = '{21'h00FFFE, 1'b0, '0};

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rows
    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      send_code(row.cp, $urandom_range(0, 2), row.fixed, row.res);
    end

    // random traffic
    foreach (workset[i]) workset[i] = 8'($urandom_range(0, 255));
    for (int i = 0; i < RAND_ITEMS; i++) begin
      send_code(draw_code(), draw_gap(), 1'b0, '0);
    end
    start_i <= 1'b0;

    // drain
    while (lookup_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("run covered %0d items: %0d hits, %0d fills, %0d static and %0d temporary",
             n_items, n_hits, n_fills, n_static_repl, n_temp_repl);
    $display("replacements over a skewed working set with out-of-plane code points");
    if (errors == 0) begin
      $display("PASS glyph_block_cache_replacement_top");
    end else begin
      $display("FAIL glyph_block_cache_replacement_top");
    end
    $finish;
  end

  // watchdog
  initial begin
    #10_000_000;
    $display("%0t: timeout, %0d results still expected", $time, lookup_q.size());
    $display("FAIL glyph_block_cache_replacement_top");
    $finish;
  end

endmodule
